>>> src/klt_pkg.sv
// Shared types, codes and the location offset table for the keyed layer table.
package klt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int LOC_COUNT   = 9;

    typedef struct packed {
        logic [9:0]  key;
        logic [16:0] pose;
        logic [3:0]  locate;
        logic [7:0]  layer;
        logic [7:0]  brightness;
        logic [7:0]  alpha;
    } t_rec;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_FIND   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_BADLOC   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_SETTLE,
        S_EMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic rot;
        logic compact;
    } t_store_ctl;

    typedef struct packed {
        logic clr;
        logic ins;
        logic shift;
    } t_sort_ctl;

    function automatic logic signed [9:0] loc_offset(input logic [3:0] loc);
        logic signed [9:0] v;
        case (loc)
            4'd0:    v = -10'sd200;
            4'd1:    v = 10'sd0;
            4'd2:    v = 10'sd200;
            4'd3:    v = -10'sd240;
            4'd4:    v = 10'sd240;
            4'd5:    v = -10'sd375;
            4'd6:    v = 10'sd375;
            4'd7:    v = -10'sd500;
            4'd8:    v = 10'sd500;
            default: v = 10'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/klt_store_cell.sv
// One slot of the record ring: rotates with its neighbours and closes gaps on removal.
module klt_store_cell #(
    parameter int ENTRIES = klt_pkg::ENTRIES_DEF,
    parameter int IDX     = 0,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  klt_pkg::t_store_ctl i_ctl,
    input  logic [IW-1:0]       i_del_idx,
    input  klt_pkg::t_rec       i_rec,
    output klt_pkg::t_rec       o_rec
);
    import klt_pkg::*;

    t_rec r_rec;
    logic w_en;

    assign w_en  = i_ctl.rot | (i_ctl.compact & (IW'(IDX) >= i_del_idx));
    assign o_rec = r_rec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rec <= i_rec;
        end
    end

endmodule

>>> src/klt_sort_cell.sv
// One cell of the systolic insertion sorter: keeps the record that sorts first, passes the other on.
module klt_sort_cell #(
    parameter int ENTRIES = klt_pkg::ENTRIES_DEF,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  klt_pkg::t_sort_ctl i_ctl,
    input  klt_pkg::t_rec      i_in_rec,
    input  logic [IW-1:0]      i_in_idx,
    input  logic               i_in_v,
    input  klt_pkg::t_rec      i_rt_rec,
    input  logic [IW-1:0]      i_rt_idx,
    input  logic               i_rt_v,
    output klt_pkg::t_rec      o_rec,
    output logic [IW-1:0]      o_idx,
    output logic               o_v,
    output klt_pkg::t_rec      o_pass_rec,
    output logic [IW-1:0]      o_pass_idx,
    output logic               o_pass_v
);
    import klt_pkg::*;

    t_rec r_rec;
    logic [IW-1:0] r_idx;
    logic r_v;
    t_rec r_prec;
    logic [IW-1:0] r_pidx;
    logic r_pv;
    logic w_take;

    // Equal layers are ordered by their position in the table, so ties keep insertion order.
    assign w_take     = i_in_v && (!r_v ||
                        ({i_in_rec.layer, i_in_idx} < {r_rec.layer, r_idx}));
    assign o_rec      = r_rec;
    assign o_idx      = r_idx;
    assign o_v        = r_v;
    assign o_pass_rec = r_prec;
    assign o_pass_idx = r_pidx;
    assign o_pass_v   = r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_v  <= 1'b0;
            r_pv <= 1'b0;
        end else if (i_ctl.shift) begin
            r_rec <= i_rt_rec;
            r_idx <= i_rt_idx;
            r_v   <= i_rt_v;
            r_pv  <= 1'b0;
        end else if (i_ctl.ins) begin
            if (w_take) begin
                r_rec  <= i_in_rec;
                r_idx  <= i_in_idx;
                r_v    <= 1'b1;
                r_prec <= r_rec;
                r_pidx <= r_idx;
                r_pv   <= r_v;
            end else begin
                r_prec <= i_in_rec;
                r_pidx <= i_in_idx;
                r_pv   <= i_in_v;
            end
        end
    end

endmodule

>>> src/keyed_layer_table.sv
// Keyed record table with in-place update, compacting removal and layer-sorted readout.
// Usage: one operation per input transaction (op plus record fields), accepted on
// i_valid and o_ready. Results leave through a registered output on o_valid and
// i_ready; o_last marks the final result of each operation. Codes 5 to 7 are
// consumed with no result.
// Every lookup rotates the record ring once, comparing the head slot; remove
// adds a compaction step, and clear does not rotate the ring. Readout feeds
// the ring into the sorter chain during the rotation, lets the chain settle,
// then emits one record per cycle while the output register is free. One
// operation is in flight at a time; o_ready is high only when the block is
// idle, and the next transaction may be taken while the last result still
// waits in the output register.
// A stalled receiver holds the output register and pauses the readout emission.
// Reset empties the table and drops any pending result; record contents are not
// cleared.
module keyed_layer_table #(
    parameter int ENTRIES = klt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [9:0]  i_entry_key,
    input  logic [16:0] i_pose,
    input  logic [3:0]  i_locate,
    input  logic [7:0]  i_layer,
    input  logic [7:0]  i_brightness,
    input  logic [7:0]  i_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_out_key,
    output logic [16:0] o_out_pose,
    output logic [3:0]  o_out_locate,
    output logic [7:0]  o_out_layer,
    output logic [7:0]  o_out_brightness,
    output logic [7:0]  o_out_alpha,
    output logic signed [9:0] o_x_offset,
    output logic        o_last
);
    import klt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state  r_state, n_state;
    t_op     r_op;
    t_rec    r_in;
    logic [CW-1:0] r_step;
    logic [CW-1:0] r_count;
    logic    r_hit;
    logic [IW-1:0] r_del;
    t_rec    r_res;
    t_status r_rstat;
    logic    r_rblank;

    logic    r_ov;
    t_rec    r_orec;
    t_status r_ostat;
    logic signed [9:0] r_oxoff;
    logic    r_olast;

    t_store_ctl w_sctl;
    t_sort_ctl  w_tctl;
    t_rec w_st   [ENTRIES];
    t_rec w_srt  [ENTRIES];
    logic [IW-1:0] w_sidx [ENTRIES];
    logic w_sv   [ENTRIES];
    t_rec w_prec [ENTRIES];
    logic [IW-1:0] w_pidx [ENTRIES];
    logic w_pv   [ENTRIES];
    t_rec w_tail;
    t_rec w_head;
    logic w_in_fire;
    logic w_out_free;
    logic w_hit_now;
    logic w_scan_end;
    logic w_write_head;
    logic w_feed;
    logic w_found;
    logic w_load_res;
    logic w_load_emit;
    logic w_emit_last;
    t_rec w_new;

    assign w_new = '{key: i_entry_key, pose: i_pose, locate: i_locate, layer: i_layer,
                     brightness: i_brightness, alpha: i_alpha};
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_fire   = i_valid & o_ready;
    assign w_out_free  = !r_ov | i_ready;
    assign w_head      = w_st[0];
    assign w_hit_now   = (r_state == S_SCAN) && (r_step < r_count) && (w_head.key == r_in.key);
    assign w_scan_end  = (r_step == CW'(ENTRIES - 1));
    assign w_found     = r_hit | w_hit_now;
    assign w_write_head = (r_op == OP_SET) &&
                          (w_hit_now || (!r_hit && (r_step == r_count)));
    assign w_feed      = (r_state == S_SCAN) && (r_op == OP_READ) && (r_step < r_count);
    assign w_tail      = w_write_head ? r_in : w_head;
    assign w_emit_last = (r_step == r_count - CW'(1));

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            t_rec w_nb_rec;
            t_rec w_left_rec;
            logic [IW-1:0] w_left_idx;
            logic w_left_v;
            t_rec w_rt_rec;
            logic [IW-1:0] w_rt_idx;
            logic w_rt_v;
            if (g == ENTRIES - 1) begin : g_end
                assign w_nb_rec = w_tail;
                assign w_rt_rec = '0;
                assign w_rt_idx = '0;
                assign w_rt_v   = 1'b0;
            end else begin : g_mid
                assign w_nb_rec = w_st[g+1];
                assign w_rt_rec = w_srt[g+1];
                assign w_rt_idx = w_sidx[g+1];
                assign w_rt_v   = w_sv[g+1];
            end
            if (g == 0) begin : g_first
                assign w_left_rec = w_head;
                assign w_left_idx = r_step[IW-1:0];
                assign w_left_v   = w_feed;
            end else begin : g_rest
                assign w_left_rec = w_prec[g-1];
                assign w_left_idx = w_pidx[g-1];
                assign w_left_v   = w_pv[g-1];
            end
            klt_store_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_store (
                .i_clk     (i_clk),
                .i_ctl     (w_sctl),
                .i_del_idx (r_del),
                .i_rec     (w_nb_rec),
                .o_rec     (w_st[g])
            );
            klt_sort_cell #(.ENTRIES(ENTRIES)) u_sort (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_tctl),
                .i_in_rec   (w_left_rec),
                .i_in_idx   (w_left_idx),
                .i_in_v     (w_left_v),
                .i_rt_rec   (w_rt_rec),
                .i_rt_idx   (w_rt_idx),
                .i_rt_v     (w_rt_v),
                .o_rec      (w_srt[g]),
                .o_idx      (w_sidx[g]),
                .o_v        (w_sv[g]),
                .o_pass_rec (w_prec[g]),
                .o_pass_idx (w_pidx[g]),
                .o_pass_v   (w_pv[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (i_op)
                        OP_SET, OP_REMOVE, OP_FIND: n_state = S_SCAN;
                        OP_CLEAR:                   n_state = S_RESP;
                        OP_READ:  n_state = (r_count == '0) ? S_RESP : S_SCAN;
                        default:                    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    if (r_op == OP_READ) begin
                        n_state = S_SETTLE;
                    end else if (r_op == OP_REMOVE && w_found) begin
                        n_state = S_COMPACT;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_COMPACT: n_state = S_RESP;
            S_SETTLE: begin
                if (r_step == CW'(ENTRIES)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_sctl      = '0;
        w_tctl      = '0;
        w_load_res  = 1'b0;
        w_load_emit = 1'b0;
        unique case (r_state)
            S_IDLE:    w_tctl.clr = w_in_fire;
            S_SCAN: begin
                w_sctl.rot = 1'b1;
                w_tctl.ins = 1'b1;
            end
            S_COMPACT: w_sctl.compact = 1'b1;
            S_SETTLE:  w_tctl.ins = 1'b1;
            S_EMIT: begin
                w_load_emit  = w_out_free;
                w_tctl.shift = w_out_free;
            end
            S_RESP:    w_load_res = w_out_free;
            default: begin
                w_sctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_op     <= t_op'(i_op);
                        r_in     <= w_new;
                        r_step   <= '0;
                        r_hit    <= 1'b0;
                        r_res    <= '0;
                        r_rblank <= 1'b1;
                        r_rstat  <= (i_op == OP_CLEAR) ? ST_OK : ST_EMPTY;
                        if (i_op == OP_CLEAR) begin
                            r_count <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + CW'(1);
                    if (w_hit_now) begin
                        r_hit <= 1'b1;
                        r_del <= r_step[IW-1:0];
                        r_res <= w_head;
                    end
                    if (w_scan_end) begin
                        r_step   <= '0;
                        r_rblank <= !w_found;
                        r_rstat  <= ST_NOTFOUND;
                        if (r_op == OP_SET) begin
                            if (w_found || (r_count < CW'(ENTRIES))) begin
                                r_rblank <= 1'b0;
                                r_res    <= r_in;
                                if (!w_found) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end else begin
                                r_rblank <= 1'b1;
                                r_rstat  <= ST_FULL;
                            end
                        end
                    end
                end
                S_COMPACT: r_count <= r_count - CW'(1);
                S_SETTLE: begin
                    r_step <= (r_step == CW'(ENTRIES)) ? '0 : r_step + CW'(1);
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_step <= r_step + CW'(1);
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_res || w_load_emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_emit) begin
            r_orec  <= w_srt[0];
            r_ostat <= (w_srt[0].locate >= 4'(LOC_COUNT)) ? ST_BADLOC : ST_OK;
            r_oxoff <= loc_offset(w_srt[0].locate);
            r_olast <= w_emit_last;
        end else if (w_load_res) begin
            r_olast <= 1'b1;
            if (r_rblank) begin
                r_orec  <= '0;
                r_ostat <= r_rstat;
                r_oxoff <= '0;
            end else begin
                r_orec  <= r_res;
                r_ostat <= (r_res.locate >= 4'(LOC_COUNT)) ? ST_BADLOC : ST_OK;
                r_oxoff <= loc_offset(r_res.locate);
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_ostat;
    assign o_out_key        = r_orec.key;
    assign o_out_pose       = r_orec.pose;
    assign o_out_locate     = r_orec.locate;
    assign o_out_layer      = r_orec.layer;
    assign o_out_brightness = r_orec.brightness;
    assign o_out_alpha      = r_orec.alpha;
    assign o_x_offset       = r_oxoff;
    assign o_last           = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("record count above table size");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count != '0))
        else $error("readout emission with an empty table");

    a_compact_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("removal did not reduce the count");

    a_sort_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_sv[0])
        else $error("sorter head empty during emission");

endmodule
